// ===== sv/skvt_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skvt_pkg: shared types and codes for the sorted key/value table
// Command and status codes of the item channel, and the command/status
// bundle between the controller and the datapath.
// ----------------------------------------------------------------------------
package skvt_pkg;

  // Item commands
  localparam logic [1:0] CMD_INSERT  = 2'd0;
  localparam logic [1:0] CMD_REM_KEY = 2'd1;
  localparam logic [1:0] CMD_REM_VAL = 2'd2;
  localparam logic [1:0] CMD_LOOKUP  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  // Datapath operations issued by the controller, one per cycle
  typedef enum logic [3:0] {
    DP_NOP,
    DP_LOAD,    // capture the item, set up the scan
    DP_READ,    // read the entry under the scan index
    DP_SHIFT,   // insert: move the entry read one slot up
    DP_PLACE,   // insert: write the new entry into the gap
    DP_KEEP,    // remove: copy the entry read down to the write pointer
    DP_DROP,    // remove: skip the entry read and count it
    DP_SKIP,    // look up: no match, advance
    DP_HIT,     // look up: capture the matching value
    DP_FINISH   // load the result register
  } dp_op_t;

  // Datapath status seen by the controller
  typedef struct packed {
    logic [1:0] cmd;
    logic       full;
    logic       scan_done;
    logic       key_ge;
    logic       key_eq;
    logic       drop;
    logic       out_busy;
  } dp_status_t;

endpackage : skvt_pkg
`default_nettype wire

// ===== sv/sorted_key_value_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_value_table_top: sorted key/value table
// Up to DEPTH entries kept in ascending key order with duplicate keys;
// insert, remove first by key, remove all by value and look up by key.
// ----------------------------------------------------------------------------
// One item is worked at a time; the input stalls from acceptance until its
// result is loaded into the output register, which then waits on out_stall
// while the next item is already taken. The entries sit in a memory with
// one write port and one registered read port. Each item is loaded, then
// every entry examined is read, then evaluated and written back, and last
// the result is loaded.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top #(
  parameter int DEPTH      = 64,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [1:0]                    in_cmd,
  input  wire logic [KEY_BITS-1:0]           in_key,
  input  wire logic [VALUE_BITS-1:0]         in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [1:0]                         out_status,
  output logic [VALUE_BITS-1:0]              out_found_value,
  output logic [$clog2(DEPTH + 1)-1:0]       out_removed_count,
  output logic [$clog2(DEPTH + 1)-1:0]       out_occupancy
);
  import skvt_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);

  dp_op_t     dp_op;
  dp_status_t dp_st;

  // Sequence each item
  skvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .dp_st    (dp_st),
    .dp_op    (dp_op)
  );

  // Hold the entries and build the result
  skvt_dp #(
    .DEPTH      (DEPTH),
    .KEY_BITS   (KEY_BITS),
    .VALUE_BITS (VALUE_BITS),
    .CW         (CW)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .dp_op             (dp_op),
    .dp_st             (dp_st),
    .in_cmd            (in_cmd),
    .in_key            (in_key),
    .in_value          (in_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found_value   (out_found_value),
    .out_removed_count (out_removed_count),
    .out_occupancy     (out_occupancy)
  );

endmodule : sorted_key_value_table_top
`default_nettype wire

// ===== sv/skvt_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skvt_ctrl: command sequencer of the sorted key/value table
// Walks each item through load, entry-by-entry read and evaluate, and
// result hand-off, issuing one datapath operation per cycle.
// ----------------------------------------------------------------------------
module skvt_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire skvt_pkg::dp_status_t dp_st,
  output skvt_pkg::dp_op_t         dp_op
);
  import skvt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EVAL,
    S_FIN
  } state_t;

  state_t state_r, state_nxt;

  // Pick the datapath operation and next state
  always_comb begin
    state_nxt = state_r;
    dp_op     = DP_NOP;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          dp_op     = DP_LOAD;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (dp_st.cmd == CMD_INSERT && dp_st.full) begin
          state_nxt = S_FIN;
        end else if (dp_st.scan_done) begin
          if (dp_st.cmd == CMD_INSERT) begin
            dp_op = DP_PLACE;
          end
          state_nxt = S_FIN;
        end else begin
          dp_op     = DP_READ;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        case (dp_st.cmd) inside
          CMD_INSERT: begin
            if (dp_st.key_ge) begin
              dp_op     = DP_SHIFT;
              state_nxt = S_CHECK;
            end else begin
              dp_op     = DP_PLACE;
              state_nxt = S_FIN;
            end
          end
          CMD_REM_KEY, CMD_REM_VAL: begin
            dp_op     = dp_st.drop ? DP_DROP : DP_KEEP;
            state_nxt = S_CHECK;
          end
          default: begin
            if (dp_st.key_eq) begin
              dp_op     = DP_HIT;
              state_nxt = S_FIN;
            end else begin
              dp_op     = DP_SKIP;
              state_nxt = S_CHECK;
            end
          end
        endcase
      end
      S_FIN: begin
        if (!dp_st.out_busy) begin
          dp_op     = DP_FINISH;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  // A result is loaded only when the output slot is free
  a_fin_free: assert property (@(posedge clk) disable iff (!rst_n)
    dp_op == DP_FINISH |-> !dp_st.out_busy)
    else $error("result loaded into a busy output slot");

  // Each accepted item leads to the scan check next cycle
  a_load_check: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == S_CHECK)
    else $error("accepted item did not start a scan");

  // Insert into a full table never writes an entry
  a_full_noplace: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CHECK && dp_st.cmd == CMD_INSERT && dp_st.full |-> dp_op == DP_NOP)
    else $error("write issued on insert into a full table");

endmodule : skvt_ctrl
`default_nettype wire

// ===== sv/skvt_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// skvt_dp: storage and datapath of the sorted key/value table
// Entry memory with one write and one registered read port, scan index,
// compaction write pointer, occupancy count and the result register.
// ----------------------------------------------------------------------------
module skvt_dp #(
  parameter int DEPTH      = 64,
  parameter int KEY_BITS   = 16,
  parameter int VALUE_BITS = 16,
  parameter int CW         = $clog2(DEPTH + 1)
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire skvt_pkg::dp_op_t      dp_op,
  output skvt_pkg::dp_status_t       dp_st,
  input  wire logic [1:0]            in_cmd,
  input  wire logic [KEY_BITS-1:0]   in_key,
  input  wire logic [VALUE_BITS-1:0] in_value,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 out_status,
  output logic [VALUE_BITS-1:0]      out_found_value,
  output logic [CW-1:0]              out_removed_count,
  output logic [CW-1:0]              out_occupancy
);
  import skvt_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int EW = KEY_BITS + VALUE_BITS;

  // Entry memory: key in the upper bits, value in the lower
  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rd_r;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          wr_en;

  logic [1:0]            cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] value_r;
  logic                  full_r;
  logic                  hit_r;
  logic [VALUE_BITS-1:0] found_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         idx_r;
  logic [CW-1:0]         w_r;
  logic [CW-1:0]         removed_r;

  logic                  out_valid_r;
  logic [1:0]            out_status_r;
  logic [VALUE_BITS-1:0] out_found_r;
  logic [CW-1:0]         out_removed_r;
  logic [CW-1:0]         out_occ_r;

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_value;

  assign rd_key   = rd_r[EW-1:VALUE_BITS];
  assign rd_value = rd_r[VALUE_BITS-1:0];

  // Insert scans down from the top entry, the others scan up from zero
  assign rd_addr = (cmd_r == CMD_INSERT) ? AW'(idx_r - CW'(1)) : AW'(idx_r);

  // Select the memory write for this operation
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = AW'(idx_r);
    wr_data = rd_r;
    case (dp_op)
      DP_SHIFT: wr_en = 1'b1;
      DP_PLACE: begin
        wr_en   = 1'b1;
        wr_data = {key_r, value_r};
      end
      DP_KEEP: begin
        wr_en   = 1'b1;
        wr_addr = AW'(w_r);
      end
      default: wr_en = 1'b0;
    endcase
  end

  // Write and read the entry memory
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_r <= mem[rd_addr];
  end

  // Status toward the controller
  always_comb begin
    dp_st.cmd       = cmd_r;
    dp_st.full      = full_r;
    dp_st.scan_done = (cmd_r == CMD_INSERT) ? (idx_r == '0) : (idx_r == count_r);
    dp_st.key_ge    = (rd_key >= key_r);
    dp_st.key_eq    = (rd_key == key_r);
    dp_st.drop      = ((cmd_r == CMD_REM_KEY) && (rd_key == key_r) && (removed_r == '0)) ||
                      ((cmd_r == CMD_REM_VAL) && (rd_value == value_r));
    dp_st.out_busy  = out_valid_r && out_stall;
  end

  // Advance the scan registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_r     <= CMD_LOOKUP;
      count_r   <= '0;
      idx_r     <= '0;
      w_r       <= '0;
      removed_r <= '0;
      full_r    <= 1'b0;
      hit_r     <= 1'b0;
    end else begin
      case (dp_op)
        DP_LOAD: begin
          cmd_r     <= in_cmd;
          key_r     <= in_key;
          value_r   <= in_value;
          idx_r     <= (in_cmd == CMD_INSERT) ? count_r : '0;
          w_r       <= '0;
          removed_r <= '0;
          full_r    <= (count_r == CW'(DEPTH));
          hit_r     <= 1'b0;
          found_r   <= '0;
        end
        DP_SHIFT: idx_r <= idx_r - CW'(1);
        DP_PLACE: count_r <= count_r + CW'(1);
        DP_KEEP: begin
          w_r   <= w_r + CW'(1);
          idx_r <= idx_r + CW'(1);
        end
        DP_DROP: begin
          removed_r <= removed_r + CW'(1);
          idx_r     <= idx_r + CW'(1);
        end
        DP_SKIP: idx_r <= idx_r + CW'(1);
        DP_HIT: begin
          hit_r   <= 1'b1;
          found_r <= rd_value;
        end
        DP_FINISH: begin
          if (cmd_r == CMD_REM_KEY || cmd_r == CMD_REM_VAL) begin
            count_r <= w_r;
          end
        end
        default: ;
      endcase
    end
  end

  // Load the result register; drop it once the beat is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (dp_op == DP_FINISH) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dp_op == DP_FINISH) begin
      out_removed_r <= removed_r;
      out_found_r   <= hit_r ? found_r : '0;
      case (cmd_r)
        CMD_INSERT: begin
          out_status_r <= full_r ? ST_FULL : ST_OK;
          out_occ_r    <= count_r;
        end
        CMD_REM_KEY: begin
          out_status_r <= (removed_r == '0) ? ST_NOT_FOUND : ST_OK;
          out_occ_r    <= w_r;
        end
        CMD_REM_VAL: begin
          out_status_r <= ST_OK;
          out_occ_r    <= w_r;
        end
        default: begin
          out_status_r <= hit_r ? ST_OK : ST_NOT_FOUND;
          out_occ_r    <= count_r;
        end
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_found_value   = out_found_r;
  assign out_removed_count = out_removed_r;
  assign out_occupancy     = out_occ_r;

  // Occupancy never exceeds the capacity
  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("occupancy above capacity");

  // Compaction: every entry read is either kept or counted as removed
  a_compact: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_r == CMD_REM_KEY || cmd_r == CMD_REM_VAL) |->
      ((CW+1)'(removed_r) + (CW+1)'(w_r)) == (CW+1)'(idx_r))
    else $error("compaction pointers out of step");

  // Remove by key takes out at most one entry
  a_rem_one: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_r == CMD_REM_KEY |-> removed_r <= CW'(1))
    else $error("remove by key dropped more than one entry");

endmodule : skvt_dp
`default_nettype wire

// ===== tb/sorted_key_value_table_top_test.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_value_table_top_test: self-checking bench for the sorted table
// Drives insert, remove-by-key, remove-by-value and look-up beats with random
// gaps and output back-pressure, mirrors the table contents in a scoreboard
// and compares every result beat field by field with the mirrored outcome.
// ----------------------------------------------------------------------------
module sorted_key_value_table_top_test;
  import skvt_pkg::*;

  localparam int DEPTH      = 64;
  localparam int KEY_BITS   = 16;
  localparam int VALUE_BITS = 16;
  localparam int CW         = $clog2(DEPTH + 1);
  localparam int RAND_ITEMS = 1500;
  localparam int HOLD_OFF   = 400;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [1:0]            status;
    logic [VALUE_BITS-1:0] found_value;
    logic [CW-1:0]         removed_count;
    logic [CW-1:0]         occupancy;
  } table_result_t;

  // Mirror of the table plus the queue of outcomes still owed by the block
  class table_scoreboard;
    logic [KEY_BITS-1:0]   keys [DEPTH];
    logic [VALUE_BITS-1:0] vals [DEPTH];
    int unsigned           count;
    table_result_t         owed [$];
    int unsigned           mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    // Apply one accepted command to the mirror and queue its outcome
    function void note_command(logic [1:0] cmd, logic [KEY_BITS-1:0] key,
                               logic [VALUE_BITS-1:0] value);
      table_result_t r;
      int pos;
      int w;
      r = '0;
      r.cmd = cmd;
      r.status = ST_OK;
      case (cmd)
        CMD_INSERT: begin
          if (count >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            pos = 0;
            while (pos < count && keys[pos] < key) pos++;
            for (int i = count; i > pos; i--) begin
              keys[i] = keys[i-1];
              vals[i] = vals[i-1];
            end
            keys[pos] = key;
            vals[pos] = value;
            count++;
          end
        end
        CMD_REM_KEY: begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < count; i++) begin
            if (keys[i] == key) begin
              for (int j = i; j + 1 < count; j++) begin
                keys[j] = keys[j+1];
                vals[j] = vals[j+1];
              end
              count--;
              r.removed_count = 1;
              r.status = ST_OK;
              break;
            end
          end
        end
        CMD_REM_VAL: begin
          w = 0;
          for (int i = 0; i < count; i++) begin
            if (vals[i] == value) begin
              r.removed_count++;
            end else begin
              keys[w] = keys[i];
              vals[w] = vals[i];
              w++;
            end
          end
          count = w;
        end
        default: begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < count; i++) begin
            if (keys[i] == key) begin
              r.found_value = vals[i];
              r.status = ST_OK;
              break;
            end
          end
        end
      endcase
      r.occupancy = count[CW-1:0];
      owed.push_back(r);
    endfunction

    // Compare one result beat with the oldest owed outcome
    function void check_result(logic [1:0] status, logic [VALUE_BITS-1:0] found_value,
                               logic [CW-1:0] removed_count, logic [CW-1:0] occupancy);
      table_result_t e;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: status=%0d found=%h removed=%0d occ=%0d",
                   status, found_value, removed_count, occupancy);
        return;
      end
      e = owed.pop_front();
      if (status !== e.status || found_value !== e.found_value ||
          removed_count !== e.removed_count || occupancy !== e.occupancy) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch cmd=%0d: exp status=%0d found=%h removed=%0d occ=%0d,",
                   e.cmd, e.status, e.found_value, e.removed_count, e.occupancy,
                   " got status=%0d found=%h removed=%0d occ=%0d",
                   status, found_value, removed_count, occupancy);
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [1:0]            in_cmd = CMD_INSERT;
  logic [KEY_BITS-1:0]   in_key = '0;
  logic [VALUE_BITS-1:0] in_value = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            out_status;
  logic [VALUE_BITS-1:0] out_found_value;
  logic [CW-1:0]         out_removed_count;
  logic [CW-1:0]         out_occupancy;

  table_scoreboard sb;
  int unsigned     results_seen = 0;
  int unsigned     idle_cycles = 0;
  int              tx_quiet = 0;
  int              rx_quiet = 0;

  sorted_key_value_table_top #(
    .DEPTH(DEPTH),
    .KEY_BITS(KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_cmd(in_cmd),
    .in_key(in_key),
    .in_value(in_value),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_found_value(out_found_value),
    .out_removed_count(out_removed_count),
    .out_occupancy(out_occupancy)
  );

  always #2 clk = ~clk;

  // Gap before a beat; now and then a run of back-to-back beats
  function automatic int pick_gap(inout int quiet);
    if (quiet == 0 && $urandom_range(0, 19) == 0) quiet = $urandom_range(10, 40);
    if (quiet > 0) begin
      quiet--;
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  // Keys: many duplicates from a small pool, hits on held keys, extremes, noise
  function automatic logic [KEY_BITS-1:0] pick_key();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return KEY_BITS'($urandom_range(0, 15));
      4, 5: begin
        if (sb.count > 0) return sb.keys[$urandom_range(0, sb.count - 1)];
        return KEY_BITS'($urandom);
      end
      6: return $urandom_range(0, 1) ? '1 : '0;
      default: return KEY_BITS'($urandom);
    endcase
  endfunction

  function automatic logic [VALUE_BITS-1:0] pick_value(bit prefer_held);
    if (prefer_held && sb.count > 0 && $urandom_range(0, 9) < 6)
      return sb.vals[$urandom_range(0, sb.count - 1)];
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return VALUE_BITS'($urandom_range(0, 7));
      5: return $urandom_range(0, 1) ? '1 : '0;
      default: return VALUE_BITS'($urandom);
    endcase
  endfunction

  // Offer one command beat and hold it until the block takes it
  task automatic send_command(logic [1:0] cmd, logic [KEY_BITS-1:0] key,
                              logic [VALUE_BITS-1:0] value);
    int gap;
    gap = pick_gap(tx_quiet);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cmd   <= cmd;
    in_key   <= key;
    in_value <= value;
    do @(posedge clk); while (in_stall);
    sb.note_command(cmd, key, value);
  endtask

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_result(out_status, out_found_value, out_removed_count, out_occupancy);
      results_seen++;
    end
  end

  // Count cycles with no beat on either channel
  always @(posedge clk) begin
    if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Test completed with failures");
    $finish;
  end

  // Receiver: random stall per beat, one long hold-off to back the block up
  initial begin
    int  gap;
    bit  held;
    held = 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = pick_gap(rx_quiet);
      if (!held && results_seen >= 300) begin
        gap  = HOLD_OFF;
        held = 1'b1;
      end
      if (gap > 0) begin
        out_stall <= 1'b1;
        repeat (gap) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Stimulus
  initial begin
    bit                    filling;
    int unsigned           r;
    logic [1:0]            cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;

    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table: every miss path
    send_command(CMD_LOOKUP,  16'h0000, 16'h0000);
    send_command(CMD_REM_KEY, 16'hFFFF, 16'h0000);
    send_command(CMD_REM_VAL, 16'h0000, 16'h0000);
    // Extremes, a duplicate key and out-of-order arrival
    send_command(CMD_INSERT,  16'h8000, 16'h1234);
    send_command(CMD_INSERT,  16'hFFFF, 16'hFFFF);
    send_command(CMD_INSERT,  16'h0000, 16'h0000);
    send_command(CMD_INSERT,  16'h8000, 16'h5678);
    send_command(CMD_INSERT,  16'h7FFF, 16'hAAAA);
    send_command(CMD_INSERT,  16'h0001, 16'h5555);
    // Look-ups: first of duplicates, both ends, zero value, miss
    send_command(CMD_LOOKUP,  16'h8000, 16'h0000);
    send_command(CMD_LOOKUP,  16'hFFFF, 16'h0000);
    send_command(CMD_LOOKUP,  16'h0000, 16'h0000);
    send_command(CMD_LOOKUP,  16'h4000, 16'h0000);
    // Remove the first duplicate, then see the second one
    send_command(CMD_REM_KEY, 16'h8000, 16'h0000);
    send_command(CMD_LOOKUP,  16'h8000, 16'h0000);
    send_command(CMD_REM_KEY, 16'h1234, 16'h0000);
    // Remove by value: one match, two matches, none
    send_command(CMD_REM_VAL, 16'h0000, 16'h5555);
    send_command(CMD_INSERT,  16'h2222, 16'hAAAA);
    send_command(CMD_REM_VAL, 16'h0000, 16'hAAAA);
    send_command(CMD_REM_VAL, 16'h0000, 16'h9999);
    send_command(CMD_REM_KEY, 16'hFFFF, 16'h0000);
    send_command(CMD_REM_KEY, 16'h0000, 16'h0000);
    send_command(CMD_REM_KEY, 16'h8000, 16'h0000);

    // Random part: alternate fill and drain phases, fill runs past full
    filling = 1'b1;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (sb.count >= DEPTH && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (sb.count == 0) filling = 1'b1;
      if ($urandom_range(0, 99) == 0) filling = ~filling;
      r = $urandom_range(0, 99);
      if (r < 8) begin
        // noise: every field drawn at random
        cmd   = 2'($urandom);
        key   = KEY_BITS'($urandom);
        value = VALUE_BITS'($urandom);
      end else begin
        r = $urandom_range(0, 99);
        if (filling)
          cmd = (r < 65) ? CMD_INSERT : (r < 75) ? CMD_REM_KEY :
                (r < 80) ? CMD_REM_VAL : CMD_LOOKUP;
        else
          cmd = (r < 15) ? CMD_INSERT : (r < 55) ? CMD_REM_KEY :
                (r < 75) ? CMD_REM_VAL : CMD_LOOKUP;
        key   = pick_key();
        value = pick_value(cmd == CMD_REM_VAL);
      end
      send_command(cmd, key, value);
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then wait on to catch any unexpected beat
    while (sb.owed.size() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);

    if (sb.mismatches == 0 && sb.owed.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule : sorted_key_value_table_top_test
`default_nettype wire

// ===== files.f =====
sv/skvt_pkg.sv
sv/skvt_ctrl.sv
sv/skvt_dp.sv
sv/sorted_key_value_table_top.sv
tb/sorted_key_value_table_top_test.sv
